FILE: rtl/double_ended_queue_unit_macros.svh
// Assertion macros shared by the deque unit.
// Every property is sampled on the rising edge of clk and is disabled while rst_n is low.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property on every clock edge outside reset.
`define DEQU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define DEQU_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define DEQU_ASSERT(label, prop, msg)
`define DEQU_ASSERT_NEVER(label, cond, msg)

`endif

`endif

FILE: rtl/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

    // Storage geometry. DEPTH is a power of two, so the slot indices wrap by truncation.
    localparam int DEPTH      = 128;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int COUNT_W    = $clog2(DEPTH + 1);
    localparam int CMD_W      = 3;

    // Command codes of the request channel.
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 3'd4;
    localparam logic [CMD_W-1:0] CMD_PEEK_BACK  = 3'd5;

    // Request payload.
    typedef struct packed {
        logic [CMD_W-1:0]             cmd;
        logic signed [DATA_WIDTH-1:0] push_value;
    } deq_req_t;

    // Response payload.
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] read_data;
        logic                         read_valid;
        logic [COUNT_W-1:0]           element_count;
        logic                         is_empty;
        logic                         rejected;
    } deq_rsp_t;

    // Operation that the datapath carries out. Rejected and unused commands become OP_NOP.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_PEEK_FRONT,
        OP_PEEK_BACK
    } deq_op_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_RESP
    } deq_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        deq_op_t op;
        logic    reject;
    } deq_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
    } deq_stat_t;

endpackage

FILE: rtl/deq_controller.sv
`timescale 1ns / 1ps

module deq_controller
    import deq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  logic [CMD_W-1:0] req_cmd,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    input  deq_stat_t        stat,
    output deq_ctl_t         ctl
);

    deq_state_t state_reg;
    deq_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state, handshake outputs and command decode.
    always_comb
    begin
        state_next = state_reg;
        req_stall  = (state_reg != ST_IDLE);
        rsp_valid  = (state_reg == ST_RESP);
        ctl        = '{load: 1'b0, op: OP_NOP, reject: 1'b0};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_RESP;

                    // A push needs room; a pop or peek needs a stored word.
                    unique case (req_cmd)
                        CMD_PUSH_FRONT:
                        begin
                            if (stat.full) ctl.reject = 1'b1;
                            else           ctl.op     = OP_PUSH_FRONT;
                        end
                        CMD_PUSH_BACK:
                        begin
                            if (stat.full) ctl.reject = 1'b1;
                            else           ctl.op     = OP_PUSH_BACK;
                        end
                        CMD_POP_FRONT:
                        begin
                            if (stat.empty) ctl.reject = 1'b1;
                            else            ctl.op     = OP_POP_FRONT;
                        end
                        CMD_POP_BACK:
                        begin
                            if (stat.empty) ctl.reject = 1'b1;
                            else            ctl.op     = OP_POP_BACK;
                        end
                        CMD_PEEK_FRONT:
                        begin
                            if (stat.empty) ctl.reject = 1'b1;
                            else            ctl.op     = OP_PEEK_FRONT;
                        end
                        CMD_PEEK_BACK:
                        begin
                            if (stat.empty) ctl.reject = 1'b1;
                            else            ctl.op     = OP_PEEK_BACK;
                        end
                        default:
                        begin
                            ctl.op = OP_NOP;
                        end
                    endcase
                end
            end
            ST_RESP:
            begin
                if (!rsp_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/deq_datapath.sv
`timescale 1ns / 1ps

`include "double_ended_queue_unit_macros.svh"

module deq_datapath
    import deq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [DATA_WIDTH-1:0] push_value,
    input  deq_ctl_t              ctl,
    output deq_stat_t             stat,
    output deq_rsp_t              rsp
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_q_reg;
    logic                  rd_valid_reg;
    logic                  reject_reg;

    logic [ADDR_W-1:0]  head_reg;
    logic [ADDR_W-1:0]  head_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] head_dec;
    logic [ADDR_W-1:0] head_inc;
    logic [ADDR_W-1:0] tail_slot;
    logic [ADDR_W-1:0] back_slot;

    // Slot positions relative to the front; all wrap modulo DEPTH.
    assign head_dec  = head_reg - ADDR_W'(1);
    assign head_inc  = head_reg + ADDR_W'(1);
    assign back_slot = head_reg + count_reg[ADDR_W-1:0];
    assign tail_slot = back_slot - ADDR_W'(1);

    assign stat.full  = (count_reg == COUNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);

    // Pointer, count and memory port control for the operation being loaded.
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = back_slot;
        rd_en      = 1'b0;
        rd_addr    = head_reg;

        if (ctl.load)
        begin
            case (ctl.op)
                OP_PUSH_FRONT:
                begin
                    wr_en      = 1'b1;
                    wr_addr    = head_dec;
                    head_next  = head_dec;
                    count_next = count_reg + COUNT_W'(1);
                end
                OP_PUSH_BACK:
                begin
                    wr_en      = 1'b1;
                    wr_addr    = back_slot;
                    count_next = count_reg + COUNT_W'(1);
                end
                OP_POP_FRONT:
                begin
                    rd_en      = 1'b1;
                    rd_addr    = head_reg;
                    head_next  = head_inc;
                    count_next = count_reg - COUNT_W'(1);
                end
                OP_POP_BACK:
                begin
                    rd_en      = 1'b1;
                    rd_addr    = tail_slot;
                    count_next = count_reg - COUNT_W'(1);
                end
                OP_PEEK_FRONT:
                begin
                    rd_en   = 1'b1;
                    rd_addr = head_reg;
                end
                OP_PEEK_BACK:
                begin
                    rd_en   = 1'b1;
                    rd_addr = tail_slot;
                end
                default:
                begin
                    rd_en = 1'b0;
                end
            endcase
        end
    end

    // Front pointer and element count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // Slot storage with a registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= push_value;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    // Result flags, captured with the transfer and held until the response is taken.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            rd_valid_reg <= rd_en;
            reject_reg   <= ctl.reject;
        end
    end

    // Response assembly; the count already reflects the command.
    assign rsp.read_data     = rd_valid_reg ? rd_q_reg : '0;
    assign rsp.read_valid    = rd_valid_reg;
    assign rsp.element_count = count_reg;
    assign rsp.is_empty      = stat.empty;
    assign rsp.rejected      = reject_reg;

    `DEQU_ASSERT_NEVER(a_count_range, count_reg > COUNT_W'(DEPTH), "element count above capacity")
    `DEQU_ASSERT_NEVER(a_push_when_full, stat.full && wr_en, "write issued to a full queue")
    `DEQU_ASSERT(a_pop_count, ctl.load && (ctl.op == OP_POP_FRONT || ctl.op == OP_POP_BACK) |=> count_reg == $past(count_reg) - COUNT_W'(1), "pop did not lower the count by one")

endmodule

FILE: rtl/double_ended_queue_unit.sv
`timescale 1ns / 1ps
// Latency: the response is offered on the cycle after the request transfer.
// A new command is stalled until the response to the last one has been taken;
// a single command is in flight, and its word comes through the registered memory read port.
// Reset clears the front pointer, the element count and the controller state at once.
// Slot storage is not cleared and holds whatever was last written.

module double_ended_queue_unit
    import deq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  deq_req_t req_data,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output deq_rsp_t rsp_data
);

    deq_ctl_t  ctl;
    deq_stat_t stat;

    // Sequencing and command decode.
    deq_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_cmd   (req_data.cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .ctl       (ctl)
    );

    // Pointers, storage and response registers.
    deq_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_value (req_data.push_value),
        .ctl        (ctl),
        .stat       (stat),
        .rsp        (rsp_data)
    );

endmodule

FILE: sim/double_ended_queue_checker.sv
`timescale 1ns / 1ps

module double_ended_queue_checker
    import deq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  logic     req_stall,
    input  deq_req_t req_data,
    input  logic     rsp_valid,
    input  logic     rsp_stall,
    input  deq_rsp_t rsp_data,
    output int       mismatch_total,
    output int       results_pending
);

    // Shadow copy of the deque contents and pointers.
    logic signed [DATA_WIDTH-1:0] slot_words [DEPTH];
    logic [ADDR_W-1:0]            front_slot;
    logic [COUNT_W-1:0]           word_count;

    // Responses predicted for accepted commands, oldest first.
    deq_rsp_t predicted_responses [$];
    int       mismatches = 0;

    // Applies one command to the shadow deque and returns the response it must produce.
    function automatic deq_rsp_t predict_response(input deq_req_t req);
        deq_rsp_t          rsp;
        logic [ADDR_W-1:0] back_slot;
        logic [ADDR_W-1:0] past_back;
        logic              full;
        logic              empty;
        rsp       = '0;
        full      = (word_count >= COUNT_W'(DEPTH));
        empty     = (word_count == '0);
        back_slot = front_slot + word_count[ADDR_W-1:0] - 1'b1;
        past_back = front_slot + word_count[ADDR_W-1:0];
        case (req.cmd)
            CMD_PUSH_FRONT:
            begin
                if (full)
                    rsp.rejected = 1'b1;
                else
                begin
                    front_slot             = front_slot - 1'b1;
                    slot_words[front_slot] = req.push_value;
                    word_count             = word_count + 1'b1;
                end
            end
            CMD_PUSH_BACK:
            begin
                if (full)
                    rsp.rejected = 1'b1;
                else
                begin
                    slot_words[past_back] = req.push_value;
                    word_count            = word_count + 1'b1;
                end
            end
            CMD_POP_FRONT, CMD_PEEK_FRONT:
            begin
                if (empty)
                    rsp.rejected = 1'b1;
                else
                begin
                    rsp.read_data  = slot_words[front_slot];
                    rsp.read_valid = 1'b1;
                    if (req.cmd == CMD_POP_FRONT)
                    begin
                        front_slot = front_slot + 1'b1;
                        word_count = word_count - 1'b1;
                    end
                end
            end
            CMD_POP_BACK, CMD_PEEK_BACK:
            begin
                if (empty)
                    rsp.rejected = 1'b1;
                else
                begin
                    rsp.read_data  = slot_words[back_slot];
                    rsp.read_valid = 1'b1;
                    if (req.cmd == CMD_POP_BACK)
                        word_count = word_count - 1'b1;
                end
            end
            default:
            begin
                // Unused codes leave the deque untouched.
            end
        endcase
        rsp.element_count = word_count;
        rsp.is_empty      = (word_count == '0);
        return rsp;
    endfunction

    // Reports one field that differs from its prediction.
    task automatic compare_field(input string field, input logic [DATA_WIDTH-1:0] want,
                                 input logic [DATA_WIDTH-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            mismatches++;
        end
    endtask

    // Checks each response transfer against the oldest prediction, then predicts
    // the response of any command transfer on the same edge.
    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        deq_rsp_t want;
        if (!rst_n)
        begin
            front_slot = '0;
            word_count = '0;
            predicted_responses.delete();
            results_pending <= 0;
            mismatch_total  <= mismatches;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (predicted_responses.size() == 0)
                begin
                    $display("%0t: response with no command waiting, got %0h",
                             $time, rsp_data);
                    mismatches++;
                end
                else
                begin
                    want = predicted_responses[0];
                    predicted_responses.delete(0);
                    compare_field("read_data", want.read_data, rsp_data.read_data);
                    compare_field("read_valid", want.read_valid, rsp_data.read_valid);
                    compare_field("element_count", want.element_count,
                                  rsp_data.element_count);
                    compare_field("is_empty", want.is_empty, rsp_data.is_empty);
                    compare_field("rejected", want.rejected, rsp_data.rejected);
                end
            end
            if (req_valid && !req_stall)
                predicted_responses = {predicted_responses, predict_response(req_data)};
            results_pending <= predicted_responses.size();
            mismatch_total  <= mismatches;
        end
    end

endmodule

FILE: sim/double_ended_queue_unit_tb.sv
`timescale 1ns / 1ps

module double_ended_queue_unit_tb;
    import deq_pkg::*;

    // Codes the block must treat as no operation.
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

    localparam logic signed [DATA_WIDTH-1:0] WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic signed [DATA_WIDTH-1:0] WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    localparam int RANDOM_ITEMS = 1630;
    localparam int HOLD_START   = 1500;
    localparam int HOLD_LEN     = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int RUN_LIMIT_NS = 5_000_000;

    typedef enum int
    {
        PH_FILL,
        PH_MIXED,
        PH_DRAIN
    } phase_t;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    deq_req_t req_data;
    logic     rsp_valid;
    logic     rsp_stall;
    deq_rsp_t rsp_data;
    int       mismatch_total;
    int       results_pending;
    int       burst_left;

    double_ended_queue_unit u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    double_ended_queue_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .req_data        (req_data),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .rsp_data        (rsp_data),
        .mismatch_total  (mismatch_total),
        .results_pending (results_pending)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard limit on the run.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("FAIL double_ended_queue_unit");
        $finish;
    end

    // Response side: stretches of different stall patterns, plus one long hold-off
    // that backs the block up into its command channel.
    initial
    begin : response_stalls
        int rx_cycle;
        int stretch;
        int style;
        rsp_stall <= 1'b0;
        rx_cycle = 0;
        forever
        begin
            style   = $urandom_range(0, 3);
            stretch = $urandom_range(8, 60);
            repeat (stretch)
            begin
                @(posedge clk);
                rx_cycle++;
                if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN)
                    rsp_stall <= 1'b1;
                else
                begin
                    case (style)
                        0: rsp_stall <= 1'b0;
                        1: rsp_stall <= ($urandom_range(0, 99) < 30);
                        2: rsp_stall <= ($urandom_range(0, 99) < 70);
                        default: rsp_stall <= rx_cycle[0];
                    endcase
                end
            end
        end
    end

    // Offers one command, opening a new burst after an idle gap when the last one ran out,
    // and returns right after the edge of its transfer.
    task automatic issue_cmd(input logic [CMD_W-1:0] cmd,
                             input logic signed [DATA_WIDTH-1:0] value);
        deq_req_t item;
        item.cmd        = cmd;
        item.push_value = value;
        if (burst_left == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 20);
        end
        req_valid <= 1'b1;
        req_data  <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        burst_left--;
    endtask

    // Stops offering until every predicted response has been seen.
    task automatic pause_until_drained();
        req_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
    endtask

    // Random word with the extremes mixed in.
    function automatic logic signed [DATA_WIDTH-1:0] pick_word();
        case ($urandom_range(0, 15))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return '0;
            3: return '1;
            default: return $urandom();
        endcase
    endfunction

    // Random command, weighted toward filling, draining or a balanced mix.
    function automatic logic [CMD_W-1:0] pick_cmd(input phase_t phase);
        int roll;
        int push_pct;
        int pop_pct;
        case (phase)
            PH_FILL:
            begin
                push_pct = 85;
                pop_pct  = 7;
            end
            PH_DRAIN:
            begin
                push_pct = 10;
                pop_pct  = 80;
            end
            default:
            begin
                push_pct = 40;
                pop_pct  = 35;
            end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < 2)
            return $urandom_range(0, 1) ? CMD_UNUSED_HI : CMD_UNUSED_LO;
        else if (roll < 2 + push_pct)
            return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        else if (roll < 2 + push_pct + pop_pct)
            return $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
        else
            return $urandom_range(0, 1) ? CMD_PEEK_BACK : CMD_PEEK_FRONT;
    endfunction

    // Command stimulus and verdict.
    initial
    begin : command_stimulus
        int              sent;
        int              span;
        int              phase_idx;
        phase_t          phase;
        logic [CMD_W-1:0] cmd;
        rst_n      <= 1'b0;
        req_valid  <= 1'b0;
        req_data   <= '0;
        burst_left = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reads and unused codes on an empty deque.
        issue_cmd(CMD_POP_FRONT, WORD_MAX);
        issue_cmd(CMD_PEEK_BACK, '0);
        issue_cmd(CMD_POP_BACK, '1);
        issue_cmd(CMD_PEEK_FRONT, WORD_MIN);
        issue_cmd(CMD_UNUSED_LO, '1);
        issue_cmd(CMD_UNUSED_HI, WORD_MIN);

        // Extremes pushed at both ends, read back from both ends until empty.
        issue_cmd(CMD_PUSH_FRONT, WORD_MAX);
        issue_cmd(CMD_PUSH_BACK, WORD_MIN);
        issue_cmd(CMD_PUSH_FRONT, '0);
        issue_cmd(CMD_PUSH_BACK, '1);
        issue_cmd(CMD_PEEK_FRONT, '0);
        issue_cmd(CMD_PEEK_BACK, '0);
        issue_cmd(CMD_UNUSED_LO, WORD_MAX);
        issue_cmd(CMD_POP_BACK, '0);
        issue_cmd(CMD_POP_FRONT, '0);
        issue_cmd(CMD_POP_BACK, '0);
        issue_cmd(CMD_POP_FRONT, '0);

        // The deque empties with the front pointer left in place; reuse it from both ends.
        issue_cmd(CMD_POP_FRONT, '0);
        issue_cmd(CMD_PUSH_BACK, 32'sh5555_5555);
        issue_cmd(CMD_POP_FRONT, '0);
        issue_cmd(CMD_PUSH_FRONT, 32'shAAAA_AAAA);
        issue_cmd(CMD_PEEK_BACK, '0);
        issue_cmd(CMD_POP_BACK, '0);
        pause_until_drained();

        // Random phases that fill the deque to capacity, mix, and drain it again.
        sent      = 0;
        phase_idx = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case (phase_idx % 4)
                0:
                begin
                    phase = PH_FILL;
                    span  = $urandom_range(170, 230);
                end
                2:
                begin
                    phase = PH_DRAIN;
                    span  = $urandom_range(170, 230);
                end
                default:
                begin
                    phase = PH_MIXED;
                    span  = $urandom_range(40, 120);
                end
            endcase
            while (span > 0 && sent < RANDOM_ITEMS)
            begin
                cmd = pick_cmd(phase);
                issue_cmd(cmd, pick_word());
                if (cmd != CMD_UNUSED_LO && cmd != CMD_UNUSED_HI)
                    sent++;
                span--;
            end
            if ($urandom_range(0, 3) == 0)
                pause_until_drained();
            phase_idx++;
        end

        // Let every response arrive, then allow a few more cycles for stray ones.
        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_total == 0 && results_pending == 0)
            $display("PASS double_ended_queue_unit");
        else
            $display("FAIL double_ended_queue_unit");
        $finish;
    end

endmodule
